>>> hw/rtl/itoa_pkg.sv
// ============================================================================
// itoa_pkg: constants for the signed integer to decimal text converter
// Character codes, digit width and the default input width that the
// conversion datapath uses.
// ============================================================================
package itoa_pkg;

    // Default width of the signed input value.
    localparam int VALUE_BITS_DEFAULT = 32;

    // Width of one output character and of the padded output data bus.
    localparam int TEXT_W     = 6;
    localparam int OUT_DATA_W = 8;

    // One BCD digit.
    localparam int DIGIT_W = 4;

    // Character codes, already cut to the 6-bit character field.
    localparam logic [TEXT_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [TEXT_W-1:0] CHAR_MINUS = 6'd45;

    // Shift-and-add-3 correction: a digit at or above the limit gets the bias.
    localparam logic [DIGIT_W-1:0] DD_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DD_BIAS  = 4'd3;

endpackage : itoa_pkg

>>> hw/rtl/signed_int_to_decimal_ascii_unit.sv
// ============================================================================
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text
// Converts one two's complement value into its decimal characters, most
// significant first, with a leading minus sign for negative values.
// ============================================================================
//
// Each request on the slave side carries one signed value; the block answers
// with one request per character on the master side, '-' first when the value
// is negative, then the digits without leading zeros (zero gives "0"), with
// tlast on the final character. The magnitude is formed unsigned, so the most
// negative value converts correctly. Conversion runs on one shift-and-add-3
// (double dabble) unit that handles one input bit per cycle, followed by a
// leading-zero skip of one digit per cycle, a step that loads the first
// character, and one character per cycle out while m_tready is high. The block
// takes no new value until the last character of the current one has been
// delivered.
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Input stream. tdata: value [VALUE_BITS-1:0], zero padding above.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,

    // Output stream. tdata: text_char [5:0], zero padding [7:6].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [itoa_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import itoa_pkg::*;

    // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
    localparam int DIGITS    = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W     = DIGITS * DIGIT_W;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                 state_reg,   state_next;
    logic [VALUE_BITS-1:0]  mag_reg,     mag_next;
    logic                   neg_reg,     neg_next;
    logic [BCD_W-1:0]       bcd_reg,     bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_reg,     dig_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TEXT_W-1:0]      out_char_reg,  out_char_next;
    logic                   out_last_reg,  out_last_next;

    logic [VALUE_BITS-1:0]  raw;
    logic [BCD_W-1:0]       bcd_adj;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   in_fire;
    logic                   out_fire;

    // Handshakes.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    assign raw       = s_tdata[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // Add-3 correction on every BCD digit ahead of the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DD_LIMIT)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DD_BIAS;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Sequencer: convert, drop leading zeros, then send the characters.
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONVERT;
                end
            end

            ST_CONVERT:
            begin
                // One magnitude bit enters the BCD register per cycle.
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_next   = DIG_CNT_W'(DIGITS);
                    state_next = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // Drop one leading zero digit per cycle, but keep the last one.
                if (top_digit == '0 && dig_reg != DIG_CNT_W'(1))
                begin
                    bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_next = dig_reg - 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                    if (neg_reg)
                    begin
                        out_char_next = CHAR_MINUS;
                        out_last_next = 1'b0;
                    end
                    else
                    begin
                        out_char_next = CHAR_ZERO + TEXT_W'(top_digit);
                        out_last_next = (dig_reg == DIG_CNT_W'(1));
                        bcd_next      = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        dig_next      = dig_reg - 1'b1;
                    end
                end
            end

            ST_EMIT:
            begin
                // Load the next digit once the current character is taken.
                if (out_fire)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_char_next = CHAR_ZERO + TEXT_W'(top_digit);
                        out_last_next = (dig_reg == DIG_CNT_W'(1));
                        bcd_next      = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        dig_next      = dig_reg - 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_reg       <= dig_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bcd_reg      <= bcd_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - TEXT_W){1'b0}}, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule : signed_int_to_decimal_ascii_unit
